### rtl/b2d_pkg.sv
// shared types and constants for the binary to decimal ascii converter
package b2d_pkg;

	localparam int IN_W    = 64;
	localparam int CHAR_W  = 8;
	localparam int DIGIT_W = 4;

	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
	localparam logic [DIGIT_W-1:0] ADD3_LIMIT = 4'd4;
	localparam logic [DIGIT_W-1:0] ADD3_VALUE = 4'd3;

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_CONV = 3'b010,
		T_EMIT = 3'b100
	} top_state_t;

	typedef enum logic [3:0] {
		E_IDLE = 4'b0001,
		E_SKIP = 4'b0010,
		E_SIGN = 4'b0100,
		E_DIG  = 4'b1000
	} emit_state_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} dab_stat_t;

	typedef struct packed {
		logic start;
		logic neg;
		logic keep_all;
	} emit_ctl_t;

endpackage

### rtl/b2d_in_if.sv
// input channel carrying one binary value per beat
interface b2d_in_if;
	import b2d_pkg::*;

	logic             valid;
	logic             ready;
	logic [IN_W-1:0]  value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

### rtl/b2d_out_if.sv
// output channel carrying one ascii character per beat
interface b2d_out_if;
	import b2d_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] text_char;
	logic              last_char;

	modport source (output valid, output text_char, output last_char, input ready);
	modport sink (input valid, input text_char, input last_char, output ready);
endinterface

### rtl/b2d_cfg_if.sv
// configuration write channel for the signed mode register
interface b2d_cfg_if;
	logic valid;
	logic ready;
	logic signed_mode;

	modport source (output valid, output signed_mode, input ready);
	modport sink (input valid, input signed_mode, output ready);
endinterface

### rtl/b2d_dabble.sv
// iterative shift-and-add-3 unit, one input bit per cycle
module b2d_dabble #(
	parameter int VALUE_WIDTH = 64,
	parameter int MAX_DIGITS  = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [VALUE_WIDTH-1:0]               mag,
	output b2d_pkg::dab_stat_t                   stat,
	output logic [MAX_DIGITS*b2d_pkg::DIGIT_W-1:0] bcd
);
	import b2d_pkg::*;

	localparam int BCD_W = MAX_DIGITS * DIGIT_W;
	localparam int CW    = $clog2(VALUE_WIDTH + 1);
	localparam logic [CW-1:0] LAST_CNT = CW'(VALUE_WIDTH - 1);

	logic                   busy_q;
	logic                   done_q;
	logic                   ovf_q;
	logic [CW-1:0]          cnt_q;
	logic [VALUE_WIDTH-1:0] shift_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       corr;

	// add 3 to every digit above 4 before the shift
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] > ADD3_LIMIT) begin
				corr[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + ADD3_VALUE;
			end else begin
				corr[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_CNT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= mag;
			bcd_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (busy_q) begin
			shift_q <= {shift_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q   <= {corr[BCD_W-2:0], shift_q[VALUE_WIDTH-1]};
			ovf_q   <= ovf_q | corr[BCD_W-1];
		end
	end

	assign stat.done = done_q;
	assign stat.ovf  = ovf_q;
	assign bcd       = bcd_q;
endmodule

### rtl/b2d_emit.sv
// character sequencer with output register, skips leading zeros
module b2d_emit #(
	parameter int MAX_DIGITS = 20
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  b2d_pkg::emit_ctl_t                     ctl,
	input  logic [MAX_DIGITS*b2d_pkg::DIGIT_W-1:0] digits,
	output logic                                   idle,
	b2d_out_if.source                              text_out
);
	import b2d_pkg::*;

	localparam int IW = $clog2(MAX_DIGITS);
	localparam logic [IW-1:0] TOP_IDX = IW'(MAX_DIGITS - 1);

	emit_state_t        state_q;
	logic [IW-1:0]      idx_q;
	logic               neg_q;
	logic               keep_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic [DIGIT_W-1:0] digits_q [MAX_DIGITS];
	logic [DIGIT_W-1:0] cur_digit;
	logic               load;
	logic               emit_now;

	assign cur_digit = digits_q[idx_q];
	assign load      = !out_valid_q || text_out.ready;
	assign emit_now  = load && (state_q == E_SIGN || state_q == E_DIG);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= E_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= emit_now;
			end
			case (state_q)
				E_IDLE: begin
					if (ctl.start) begin
						idx_q   <= TOP_IDX;
						state_q <= E_SKIP;
					end
				end
				E_SKIP: begin
					if (!keep_q && idx_q != '0 && cur_digit == '0) begin
						idx_q <= idx_q - 1'b1;
					end else if (neg_q) begin
						state_q <= E_SIGN;
					end else begin
						state_q <= E_DIG;
					end
				end
				E_SIGN: begin
					if (load) begin
						state_q <= E_DIG;
					end
				end
				E_DIG: begin
					if (load) begin
						if (idx_q == '0) begin
							state_q <= E_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && ctl.start) begin
			neg_q  <= ctl.neg;
			keep_q <= ctl.keep_all;
			for (int i = 0; i < MAX_DIGITS; i++) begin
				digits_q[i] <= digits[i*DIGIT_W +: DIGIT_W];
			end
		end
		if (emit_now) begin
			if (state_q == E_SIGN) begin
				char_q <= CHAR_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit};
				last_q <= (idx_q == '0);
			end
		end
	end

	assign idle               = (state_q == E_IDLE);
	assign text_out.valid     = out_valid_q;
	assign text_out.text_char = char_q;
	assign text_out.last_char = last_q;
endmodule

### rtl/binary_to_decimal_ascii_unit.sv
// top level of the binary to decimal ascii converter
//
//  channel   dir  payload                      beat
//  num_in    in   value[63:0]                  one integer
//  text_out  out  text_char[7:0], last_char    one character
//  cfg       in   signed_mode                  one register write
//
// an item passes through the shift-and-add-3 unit, then the sequencer skips
// leading zero digits, then emits the characters while text_out is ready;
// a minus sign, if any, is sent before the digits.
// num_in is ready only when the sequencer is idle; the last character may
// still sit in the output register when the next value is taken.
// reset sets signed_mode to 1 and empties the output register.
module binary_to_decimal_ascii_unit #(
	parameter int VALUE_WIDTH = 64,
	parameter int MAX_DIGITS  = 20
) (
	input  logic      clk,
	input  logic      arst_n,
	b2d_in_if.sink    num_in,
	b2d_out_if.source text_out,
	b2d_cfg_if.sink   cfg
);
	import b2d_pkg::*;

	top_state_t                   state_q;
	logic                         signed_q;
	logic                         neg_q;
	logic                         accept;
	logic                         in_neg;
	logic [VALUE_WIDTH-1:0]       in_v;
	logic [VALUE_WIDTH-1:0]       in_mag;
	dab_stat_t                    dab_stat;
	logic [MAX_DIGITS*DIGIT_W-1:0] bcd;
	emit_ctl_t                    ectl;
	logic                         emit_idle;

	assign cfg.ready    = 1'b1;
	assign num_in.ready = (state_q == T_IDLE);
	assign accept       = num_in.valid && num_in.ready;

	assign in_v   = num_in.value[VALUE_WIDTH-1:0];
	assign in_neg = signed_q && in_v[VALUE_WIDTH-1];
	assign in_mag = in_neg ? (~in_v + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : in_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_q <= 1'b1;
			state_q  <= T_IDLE;
			neg_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				signed_q <= cfg.signed_mode;
			end
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						neg_q   <= in_neg;
						state_q <= T_CONV;
					end
				end
				T_CONV: begin
					if (dab_stat.done) begin
						state_q <= T_EMIT;
					end
				end
				T_EMIT: begin
					if (emit_idle) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign ectl.start    = (state_q == T_CONV) && dab_stat.done;
	assign ectl.neg      = neg_q;
	assign ectl.keep_all = dab_stat.ovf;

	b2d_dabble #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.MAX_DIGITS (MAX_DIGITS)
	) u_dabble (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.mag   (in_mag),
		.stat  (dab_stat),
		.bcd   (bcd)
	);

	b2d_emit #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ectl),
		.digits  (bcd),
		.idle    (emit_idle),
		.text_out(text_out)
	);
endmodule
